// File: src/ordered_timer_pool_unit_defines.svh
// Assertion macros shared by the timer pool RTL.
`ifndef ORDERED_TIMER_POOL_UNIT_DEFINES_SVH
`define ORDERED_TIMER_POOL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer pool check failed");
`define OTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer pool check failed");
`else
`define OTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/otp_pkg.sv
// Shared constants for the ordered timer pool.
`timescale 1ns / 1ps
package otp_pkg;
    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_BIND  = 3'd2;
    localparam logic [2:0] REQ_ARM   = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_EXPIRE = 2'd2;

    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_ARMED = 2'd2;

    localparam int          MAX_RESULTS = 32;
    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;
endpackage

// File: src/otp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module otp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/ordered_timer_pool_unit.sv
// Top level of the ordered timer pool with its list walker.
//
// Channel   Direction  Handshake                 Fields
// in        input      i_in_valid / o_in_stall   req_type timer_index queue_id payload delay_ticks
// out       output     o_out_valid / i_out_stall status slot dest_queue event_word last
//
// One request is worked at a time; alloc, bind and unknown codes give their result from S_RES
// once the output register is free, and the block then takes the next request in S_IDLE.
// Free of an armed timer walks the list at one node per cycle to unlink it; arm of an unarmed
// timer walks the list to find the timer's place by deadline and links it in there.
// Re-arming an armed timer unlinks it first and walks twice, once to unlink it and once to insert it.
// A tick walks the expired prefix at one node per cycle, one result per cycle when not stalled.
// Reset clears the slot modes, tick count and list registers; the memories need no clearing.
// A stalled output holds the tick walk in place until the result register frees.
`timescale 1ns / 1ps
`include "ordered_timer_pool_unit_defines.svh"
module ordered_timer_pool_unit #(
    parameter int TIMER_SLOTS   = 32,
    parameter int QUEUE_ID_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [4:0]  i_timer_index,
    input  logic [3:0]  i_queue_id,
    input  logic [31:0] i_payload,
    input  logic [31:0] i_delay_ticks,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [3:0]  o_dest_queue,
    output logic [31:0] o_event_word,
    output logic        o_last
);
    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int QB = QUEUE_ID_BITS;
    localparam int QW = QB + 32;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_RES      = 15'b000000000000010,
        S_UL       = 15'b000000000000100,
        S_UL_HEAD  = 15'b000000000001000,
        S_UL_LINK  = 15'b000000000010000,
        S_UL_FIX   = 15'b000000000100000,
        S_UL_RDH   = 15'b000000001000000,
        S_UL_REF   = 15'b000000010000000,
        S_INS      = 15'b000000100000000,
        S_INS_LINK = 15'b000001000000000,
        S_INS_CMP  = 15'b000010000000000,
        S_WR1      = 15'b000100000000000,
        S_WR2      = 15'b001000000000000,
        S_TK       = 15'b010000000000000,
        S_TK_CMP   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_mode [TIMER_SLOTS];
    logic [1:0]    n_mode [TIMER_SLOTS];
    logic          r_op_arm, n_op_arm;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_d, n_d;
    logic [31:0]   r_tick, n_tick;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_earliest, n_earliest;
    logic [IW-1:0] r_prev, n_prev;
    logic [IW-1:0] r_nxt, n_nxt;
    logic [CW-1:0] r_k, n_k;
    logic [IW-1:0] r_x, n_x;
    logic          r_two, n_two;
    logic [IW-1:0] r_i, n_i;
    logic [CW-1:0] r_n, n_n;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pslot, n_pslot;
    logic [QW-1:0] r_pqw, n_pqw;
    logic [1:0]    r_rstatus, n_rstatus;
    logic [4:0]    r_rslot, n_rslot;
    logic          r_ov, n_ov;
    logic [1:0]    r_ostatus, n_ostatus;
    logic [4:0]    r_oslot, n_oslot;
    logic [3:0]    r_oqueue, n_oqueue;
    logic [31:0]   r_oword, n_oword;
    logic          r_olast, n_olast;

    logic          dl_we, dl_re, lk_we, lk_re, qw_we, qw_re;
    logic [IW-1:0] dl_waddr, dl_raddr, lk_waddr, lk_raddr, qw_raddr;
    logic [31:0]   dl_wdata, dl_q;
    logic [IW-1:0] lk_wdata, lk_q;
    logic [QW-1:0] qw_wdata, qw_q;

    logic          in_acc, out_free, idx_ok, free_found;
    logic [IW-1:0] idx_in, free_idx;
    logic [CW-1:0] k_inc;

    otp_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_deadline (
        .i_clk(i_clk), .i_we(dl_we), .i_waddr(dl_waddr), .i_wdata(dl_wdata),
        .i_re(dl_re), .i_raddr(dl_raddr), .o_rdata(dl_q)
    );
    otp_ram #(.WIDTH(IW), .DEPTH(TIMER_SLOTS)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_re(lk_re), .i_raddr(lk_raddr), .o_rdata(lk_q)
    );
    otp_ram #(.WIDTH(QW), .DEPTH(TIMER_SLOTS)) u_binding (
        .i_clk(i_clk), .i_we(qw_we), .i_waddr(idx_in), .i_wdata(qw_wdata),
        .i_re(qw_re), .i_raddr(qw_raddr), .o_rdata(qw_q)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);
    assign out_free     = !r_ov || !i_out_stall;
    assign idx_ok       = int'(i_timer_index) < TIMER_SLOTS;
    assign idx_in       = IW'(i_timer_index);
    assign k_inc        = r_k + 1'b1;
    assign qw_wdata     = {QB'(i_queue_id), i_payload};
    assign qw_we        = in_acc && (i_req_type == otp_pkg::REQ_BIND) && idx_ok;
    assign o_out_valid  = r_ov;
    assign o_status     = r_ostatus;
    assign o_slot       = r_oslot;
    assign o_dest_queue = r_oqueue;
    assign o_event_word = r_oword;
    assign o_last       = r_olast;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
            if (r_mode[s] == otp_pkg::MODE_FREE) begin
                free_found = 1'b1;
                free_idx   = IW'(s);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_op_arm   = r_op_arm;
        n_idx      = r_idx;
        n_d        = r_d;
        n_tick     = r_tick;
        n_head     = r_head;
        n_count    = r_count;
        n_earliest = r_earliest;
        n_prev     = r_prev;
        n_nxt      = r_nxt;
        n_k        = r_k;
        n_x        = r_x;
        n_two      = r_two;
        n_i        = r_i;
        n_n        = r_n;
        n_pv       = r_pv;
        n_pslot    = r_pslot;
        n_pqw      = r_pqw;
        n_rstatus  = r_rstatus;
        n_rslot    = r_rslot;
        n_ov       = r_ov && i_out_stall;
        n_ostatus  = r_ostatus;
        n_oslot    = r_oslot;
        n_oqueue   = r_oqueue;
        n_oword    = r_oword;
        n_olast    = r_olast;
        dl_we      = 1'b0;
        dl_waddr   = r_idx;
        dl_wdata   = r_d;
        dl_re      = 1'b0;
        dl_raddr   = r_head;
        lk_we      = 1'b0;
        lk_waddr   = r_idx;
        lk_wdata   = r_x;
        lk_re      = 1'b0;
        lk_raddr   = r_head;
        qw_re      = 1'b0;
        qw_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx     = idx_in;
                    n_rstatus = otp_pkg::ST_DONE;
                    n_rslot   = '0;
                    n_op_arm  = 1'b0;
                    n_state   = S_RES;
                    unique case (i_req_type)
                        otp_pkg::REQ_ALLOC: begin
                            if (free_found) begin
                                n_mode[free_idx] = otp_pkg::MODE_ALLOC;
                                n_rslot          = 5'(free_idx);
                            end else begin
                                n_rstatus = otp_pkg::ST_NONE;
                            end
                        end
                        otp_pkg::REQ_FREE: begin
                            if (idx_ok) begin
                                n_mode[idx_in] = otp_pkg::MODE_FREE;
                                if (r_mode[idx_in] == otp_pkg::MODE_ARMED) begin
                                    n_state = S_UL;
                                end
                            end
                        end
                        otp_pkg::REQ_ARM: begin
                            if (idx_ok) begin
                                n_mode[idx_in] = otp_pkg::MODE_ARMED;
                                n_d            = i_delay_ticks + r_tick;
                                n_op_arm       = 1'b1;
                                n_state = (r_mode[idx_in] == otp_pkg::MODE_ARMED) ? S_UL : S_INS;
                            end
                        end
                        otp_pkg::REQ_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_state = S_TK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_ostatus = r_rstatus;
                    n_oslot   = r_rslot;
                    n_oqueue  = '0;
                    n_oword   = '0;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_UL: begin
                lk_re = 1'b1;
                if (r_head == r_idx) begin
                    lk_raddr = r_idx;
                    n_state  = S_UL_HEAD;
                end else begin
                    lk_raddr = r_head;
                    n_prev   = r_head;
                    n_k      = CW'(1);
                    n_state  = S_UL_LINK;
                end
            end
            S_UL_HEAD: begin
                n_head  = lk_q;
                n_state = S_UL_RDH;
            end
            S_UL_LINK: begin
                if (lk_q == r_idx) begin
                    lk_re    = 1'b1;
                    lk_raddr = r_idx;
                    n_state  = S_UL_FIX;
                end else if (k_inc < r_count) begin
                    lk_re    = 1'b1;
                    lk_raddr = lk_q;
                    n_prev   = lk_q;
                    n_k      = k_inc;
                end else begin
                    n_state = S_UL_RDH;
                end
            end
            S_UL_FIX: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev;
                lk_wdata = lk_q;
                n_state  = S_UL_RDH;
            end
            S_UL_RDH: begin
                n_count  = r_count - 1'b1;
                dl_re    = 1'b1;
                dl_raddr = r_head;
                n_state  = S_UL_REF;
            end
            S_UL_REF: begin
                n_earliest = (r_count != '0) ? dl_q : otp_pkg::NO_DEADLINE;
                n_state    = r_op_arm ? S_INS : S_RES;
            end
            S_INS: begin
                dl_we = 1'b1;
                if (r_count == '0) begin
                    n_head     = r_idx;
                    n_x        = '0;
                    n_two      = 1'b0;
                    n_earliest = r_d;
                    n_state    = S_WR1;
                end else if (r_d <= r_earliest) begin
                    n_head     = r_idx;
                    n_x        = r_head;
                    n_two      = 1'b0;
                    n_earliest = r_d;
                    n_state    = S_WR1;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = r_head;
                    n_prev   = r_head;
                    n_k      = CW'(1);
                    n_two    = 1'b1;
                    n_state  = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                if (r_k < r_count) begin
                    n_nxt    = lk_q;
                    dl_re    = 1'b1;
                    dl_raddr = lk_q;
                    lk_re    = 1'b1;
                    lk_raddr = lk_q;
                    n_state  = S_INS_CMP;
                end else begin
                    n_x     = lk_q;
                    n_state = S_WR1;
                end
            end
            S_INS_CMP: begin
                if (r_d <= dl_q) begin
                    n_x     = r_nxt;
                    n_state = S_WR1;
                end else begin
                    n_prev = r_nxt;
                    n_k    = k_inc;
                    if (k_inc < r_count) begin
                        n_nxt    = lk_q;
                        dl_re    = 1'b1;
                        dl_raddr = lk_q;
                        lk_re    = 1'b1;
                        lk_raddr = lk_q;
                    end else begin
                        n_x     = lk_q;
                        n_state = S_WR1;
                    end
                end
            end
            S_WR1: begin
                lk_we    = 1'b1;
                lk_waddr = r_idx;
                lk_wdata = r_x;
                if (r_two) begin
                    n_state = S_WR2;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_RES;
                end
            end
            S_WR2: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev;
                lk_wdata = r_idx;
                n_count  = r_count + 1'b1;
                n_state  = S_RES;
            end
            S_TK: begin
                dl_re    = 1'b1;
                dl_raddr = r_head;
                lk_re    = 1'b1;
                lk_raddr = r_head;
                qw_re    = 1'b1;
                qw_raddr = r_head;
                n_i      = r_head;
                n_n      = '0;
                n_pv     = 1'b0;
                n_state  = S_TK_CMP;
            end
            S_TK_CMP: begin
                if (out_free) begin
                    if ((r_n < r_count) && (int'(r_n) < otp_pkg::MAX_RESULTS)
                            && (dl_q <= r_tick)) begin
                        if (r_pv) begin
                            n_ov      = 1'b1;
                            n_ostatus = otp_pkg::ST_EXPIRE;
                            n_oslot   = 5'(r_pslot);
                            n_oqueue  = 4'(r_pqw[QW-1:32]);
                            n_oword   = r_pqw[31:0];
                            n_olast   = 1'b0;
                        end
                        n_pv          = 1'b1;
                        n_pslot       = r_i;
                        n_pqw         = qw_q;
                        n_mode[r_i]   = otp_pkg::MODE_ALLOC;
                        n_n           = r_n + 1'b1;
                        n_i           = lk_q;
                        dl_re         = 1'b1;
                        dl_raddr      = lk_q;
                        lk_re         = 1'b1;
                        lk_raddr      = lk_q;
                        qw_re         = 1'b1;
                        qw_raddr      = lk_q;
                    end else begin
                        n_count    = r_count - r_n;
                        n_head     = r_i;
                        n_earliest = (r_count != r_n) ? dl_q : otp_pkg::NO_DEADLINE;
                        n_ov       = 1'b1;
                        n_olast    = 1'b1;
                        n_pv       = 1'b0;
                        if (r_pv) begin
                            n_ostatus = otp_pkg::ST_EXPIRE;
                            n_oslot   = 5'(r_pslot);
                            n_oqueue  = 4'(r_pqw[QW-1:32]);
                            n_oword   = r_pqw[31:0];
                        end else begin
                            n_ostatus = otp_pkg::ST_DONE;
                            n_oslot   = '0;
                            n_oqueue  = '0;
                            n_oword   = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                r_mode[s] <= otp_pkg::MODE_FREE;
            end
            r_tick     <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_earliest <= otp_pkg::NO_DEADLINE;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_tick     <= n_tick;
            r_head     <= n_head;
            r_count    <= n_count;
            r_earliest <= n_earliest;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_arm  <= n_op_arm;
        r_idx     <= n_idx;
        r_d       <= n_d;
        r_prev    <= n_prev;
        r_nxt     <= n_nxt;
        r_k       <= n_k;
        r_x       <= n_x;
        r_two     <= n_two;
        r_i       <= n_i;
        r_n       <= n_n;
        r_pslot   <= n_pslot;
        r_pqw     <= n_pqw;
        r_rstatus <= n_rstatus;
        r_rslot   <= n_rslot;
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
        r_oqueue  <= n_oqueue;
        r_oword   <= n_oword;
        r_olast   <= n_olast;
    end

    `OTP_ASSERT_IMPLY(a_empty_no_deadline, i_clk, i_rst_n, (r_state == S_IDLE) && (r_count == '0), r_earliest == otp_pkg::NO_DEADLINE)
    `OTP_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE)
    `OTP_ASSERT_IMPLY(a_pending_in_walk, i_clk, i_rst_n, r_pv, r_state == S_TK_CMP)
    `OTP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, r_state == S_IDLE, r_count <= CW'(TIMER_SLOTS))
endmodule
